[sv/wall_avoid_motion_fsm_macros.svh]
// ---------------------------------------------------------------------------
// Wall avoidance motion FSM: assertion macros
// Short forms for the concurrent checks used by the port checker.
// Each macro expects clk to be visible where it is used, and the first two also rst.
// ---------------------------------------------------------------------------
`ifndef WALL_AVOID_MOTION_FSM_MACROS_SVH
`define WALL_AVOID_MOTION_FSM_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define WAMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset
`define WAMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Same-cycle implication that also holds across reset
`define WAMF_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

[sv/wamf_pkg.sv]
// ---------------------------------------------------------------------------
// Wall avoidance motion FSM: package
// Item, result, state and configuration types plus shared constants.
// ---------------------------------------------------------------------------
`default_nettype none

package wamf_pkg;

  localparam int NUM_FACES = 4;
  localparam int FACE_IDX_W = $clog2(NUM_FACES);
  localparam int TIME_W = 32;
  localparam int POWER_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // "wall" as four bytes, first byte in the top bits
  localparam logic [31:0] WALL_WORD = 32'h7761_6C6C;
  localparam logic [7:0] MIN_WALL_LEN = 8'd4;

  localparam logic OP_MSG = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [TIME_W-1:0] WALL_MEM_RESET = 32'd300;
  localparam logic [TIME_W-1:0] TURN_RESET = 32'd300;
  localparam logic [TIME_W-1:0] COMMIT_RESET = 32'd1000;
  localparam logic [POWER_W-1:0] HALF_POWER_RESET = 10'd512;

  typedef enum logic [1:0] {
    ACT_FWD    = 2'd0,
    ACT_LEFT   = 2'd1,
    ACT_RIGHT  = 2'd2,
    ACT_COMMIT = 2'd3
  } move_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WALL_MEM    = 3'd0,
    REG_TURN        = 3'd1,
    REG_COMMIT      = 3'd2,
    REG_LEFT_POWER  = 3'd3,
    REG_LEFT_DIR    = 3'd4,
    REG_RIGHT_POWER = 3'd5,
    REG_RIGHT_DIR   = 3'd6,
    REG_HALF_POWER  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        op;
    logic [31:0] time_ms;
    logic [31:0] payload_head;
    logic [7:0]  payload_len;
    logic [2:0]  face;
    logic        random_bit;
  } item_t;

  typedef struct packed {
    logic [NUM_FACES-1:0] face_leds;
    move_t                action;
    logic [POWER_W-1:0]   left_power;
    logic                 left_dir;
    logic [POWER_W-1:0]   right_power;
    logic                 right_dir;
  } result_t;

  typedef struct packed {
    logic [TIME_W-1:0]  wall_memory_time;
    logic [TIME_W-1:0]  turn_time;
    logic [TIME_W-1:0]  commit_time;
    logic [POWER_W-1:0] left_cal_power;
    logic               left_cal_dir;
    logic [POWER_W-1:0] right_cal_power;
    logic               right_cal_dir;
    logic [POWER_W-1:0] half_power;
  } cfg_t;

  typedef struct packed {
    logic [NUM_FACES-1:0][TIME_W-1:0] last_seen;
    move_t                            act;
    logic [TIME_W-1:0]                deadline;
  } state_t;

endpackage

`default_nettype wire

[sv/wamf_decide.sv]
// ---------------------------------------------------------------------------
// Wall avoidance motion FSM: decision logic
// Face stamping, wall activity, action choice and wheel drive for one item.
// ---------------------------------------------------------------------------
`default_nettype none

module wamf_decide (
  input  wamf_pkg::item_t   item,
  input  wamf_pkg::cfg_t    cfg,
  input  wamf_pkg::state_t  st,
  output wamf_pkg::state_t  st_next,
  output wamf_pkg::result_t res
);
  import wamf_pkg::*;

  logic                             stamp;
  logic [NUM_FACES-1:0][TIME_W-1:0] seen;
  logic [NUM_FACES-1:0][TIME_W-1:0] age;
  logic [NUM_FACES-1:0]             active;
  logic                             front, right, back, left;
  logic                             many;
  logic                             turning;
  logic                             pending;
  logic [TIME_W-1:0]                since_dl;
  move_t                            rnd_turn;
  move_t                            act_n;
  logic                             set_dl;
  logic [TIME_W-1:0]                addend;
  logic                             clear;

  always_comb begin
    stamp = (item.op == OP_MSG) && (item.payload_len >= MIN_WALL_LEN) &&
            (item.payload_head == WALL_WORD) && (item.face[2] == 1'b0);
    for (int f = 0; f < NUM_FACES; f++) begin
      seen[f] = (stamp && item.face[FACE_IDX_W-1:0] == FACE_IDX_W'(f)) ?
                item.time_ms : st.last_seen[f];
      age[f] = item.time_ms - seen[f];
      // zero stamp means never seen
      active[f] = (seen[f] != '0) && (age[f] <= cfg.wall_memory_time);
    end
  end

  assign front = active[0];
  assign right = active[1];
  assign back  = active[2];
  assign left  = active[3];
  assign many  = (front & right & back) | (front & right & left) |
                 (front & back & left) | (right & back & left);

  assign turning  = (st.act == ACT_LEFT) || (st.act == ACT_RIGHT);
  assign since_dl = item.time_ms - st.deadline;
  assign pending  = since_dl[TIME_W-1];
  assign rnd_turn = item.random_bit ? ACT_LEFT : ACT_RIGHT;

  always_comb begin
    act_n  = st.act;
    set_dl = 1'b0;
    addend = cfg.turn_time;
    clear  = 1'b0;
    if (item.op == OP_TICK && !(turning && pending)) begin
      if (many && st.act == ACT_FWD) begin
        act_n  = rnd_turn;
        set_dl = 1'b1;
      end else if (many && turning) begin
        // boxed in: long commit and forget every wall
        act_n  = ACT_COMMIT;
        set_dl = 1'b1;
        addend = {cfg.commit_time[TIME_W-2:0], 1'b0};
        clear  = 1'b1;
      end else if (many && pending) begin
        act_n = st.act;
      end else if (st.act == ACT_COMMIT && pending) begin
        if (front) begin
          act_n  = rnd_turn;
          set_dl = 1'b1;
        end
      end else if (turning) begin
        act_n  = ACT_COMMIT;
        set_dl = 1'b1;
        addend = cfg.commit_time;
      end else if (front) begin
        set_dl = 1'b1;
        if (left && !right) begin
          act_n = ACT_RIGHT;
        end else if (right && !left) begin
          act_n = ACT_LEFT;
        end else begin
          act_n = rnd_turn;
        end
      end else if (left && !right) begin
        act_n  = ACT_RIGHT;
        set_dl = 1'b1;
      end else if (right && !left) begin
        act_n  = ACT_LEFT;
        set_dl = 1'b1;
      end else begin
        act_n = ACT_FWD;
      end
    end
  end

  always_comb begin
    for (int f = 0; f < NUM_FACES; f++) begin
      st_next.last_seen[f] = clear ? '0 : seen[f];
    end
    st_next.act      = act_n;
    st_next.deadline = set_dl ? (item.time_ms + addend) : st.deadline;
  end

  always_comb begin
    res.face_leds   = active;
    res.action      = act_n;
    res.left_power  = cfg.left_cal_power;
    res.left_dir    = cfg.left_cal_dir;
    res.right_power = cfg.right_cal_power;
    res.right_dir   = cfg.right_cal_dir;
    case (act_n)
      ACT_LEFT: begin
        res.left_power  = cfg.half_power;
        res.right_power = cfg.half_power;
        res.left_dir    = ~cfg.left_cal_dir;
      end
      ACT_RIGHT: begin
        res.left_power  = cfg.half_power;
        res.right_power = cfg.half_power;
        res.right_dir   = ~cfg.right_cal_dir;
      end
      default: begin
        res.left_power = cfg.left_cal_power;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/wall_avoid_motion_fsm.sv]
// ---------------------------------------------------------------------------
// Wall avoidance motion FSM
// Stamps wall messages per face and decides wheel drive on control ticks.
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_stall    op time_ms payload_head payload_len face random_bit
//  out       out_valid / out_stall  face_leds action left_power left_dir right_power right_dir
//  cfg       cfg_write              cfg_index cfg_data
//
// One item per cycle while out_stall is low; an item passes the input register, then the result register.
// State is updated as an item leaves the input register, so the next item sees it.
// Reset clears face memory, action, deadline and restores register defaults.
// in_stall rises only when both registers hold items and out_stall is high.
`default_nettype none

module wall_avoid_motion_fsm (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             in_valid,
  output logic                            in_stall,
  input  wire                             op,
  input  wire  [31:0]                     time_ms,
  input  wire  [31:0]                     payload_head,
  input  wire  [7:0]                      payload_len,
  input  wire  [2:0]                      face,
  input  wire                             random_bit,
  output logic                            out_valid,
  input  wire                             out_stall,
  output logic [wamf_pkg::NUM_FACES-1:0]  face_leds,
  output logic [1:0]                      action,
  output logic [wamf_pkg::POWER_W-1:0]    left_power,
  output logic                            left_dir,
  output logic [wamf_pkg::POWER_W-1:0]    right_power,
  output logic                            right_dir,
  input  wire                             cfg_write,
  input  wire  [wamf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire  [wamf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import wamf_pkg::*;

  logic    s1_valid;
  item_t   s1_item;
  logic    s1_go;
  logic    take;
  result_t res;
  result_t res_next;
  state_t  st;
  state_t  st_next;
  cfg_t    cfg;

  assign s1_go    = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_go;
  assign take     = in_valid && !in_stall;

  wamf_decide u_decide (
    .item    (s1_item),
    .cfg     (cfg),
    .st      (st),
    .st_next (st_next),
    .res     (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      st        <= '{last_seen: '0, act: ACT_FWD, deadline: '0};
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        out_valid <= 1'b1;
        st        <= st_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item <= '{op: op, time_ms: time_ms, payload_head: payload_head,
                   payload_len: payload_len, face: face, random_bit: random_bit};
    end
    if (s1_go) begin
      res <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{wall_memory_time: WALL_MEM_RESET, turn_time: TURN_RESET,
               commit_time: COMMIT_RESET, left_cal_power: '0, left_cal_dir: 1'b0,
               right_cal_power: '0, right_cal_dir: 1'b0,
               half_power: HALF_POWER_RESET};
    end else if (cfg_write) begin
      case (reg_idx_t'(cfg_index))
        REG_WALL_MEM:    cfg.wall_memory_time <= cfg_data[TIME_W-1:0];
        REG_TURN:        cfg.turn_time        <= cfg_data[TIME_W-1:0];
        REG_COMMIT:      cfg.commit_time      <= cfg_data[TIME_W-1:0];
        REG_LEFT_POWER:  cfg.left_cal_power   <= cfg_data[POWER_W-1:0];
        REG_LEFT_DIR:    cfg.left_cal_dir     <= cfg_data[0];
        REG_RIGHT_POWER: cfg.right_cal_power  <= cfg_data[POWER_W-1:0];
        REG_RIGHT_DIR:   cfg.right_cal_dir    <= cfg_data[0];
        REG_HALF_POWER:  cfg.half_power       <= cfg_data[POWER_W-1:0];
        default:         cfg.half_power       <= cfg.half_power;
      endcase
    end
  end

  assign face_leds   = res.face_leds;
  assign action      = res.action;
  assign left_power  = res.left_power;
  assign left_dir    = res.left_dir;
  assign right_power = res.right_power;
  assign right_dir   = res.right_dir;

endmodule

`default_nettype wire

[sv/wamf_checker.sv]
// ---------------------------------------------------------------------------
// Wall avoidance motion FSM: port checker
// Watches the top level's ports for flow control and drive consistency.
// ---------------------------------------------------------------------------
`default_nettype none

`include "wall_avoid_motion_fsm_macros.svh"

module wamf_checker (
  input wire        clk,
  input wire        rst,
  input wire        in_stall,
  input wire        out_valid,
  input wire        out_stall,
  input wire [1:0]  action,
  input wire [9:0]  left_power,
  input wire [9:0]  right_power
);
  import wamf_pkg::*;

  logic spinning;

  assign spinning = (action == ACT_LEFT) || (action == ACT_RIGHT);

  // a held result stays offered
  `WAMF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped while stalled")
  // input only backs up when the output side is full and stalled
  `WAMF_ASSERT_NOW(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without cause")
  // spinning drives the same power on both wheels
  `WAMF_ASSERT_NOW(a_spin_power, out_valid && spinning, left_power == right_power, "unequal spin power")
  // nothing offered straight after reset
  `WAMF_ASSERT_ALWAYS(a_reset_empty, $past(rst), !out_valid, "result offered after reset")

endmodule

bind wall_avoid_motion_fsm wamf_checker u_wamf_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .action      (action),
  .left_power  (left_power),
  .right_power (right_power)
);

`default_nettype wire

[tb/tb_wall_avoid_motion_fsm.sv]
// ---------------------------------------------------------------------------
// Wall avoidance motion FSM: regression bench
// Drives message and tick items through the block and predicts every result
// with its own copy of face memory, action and deadline. A directed sequence
// walks the turn, commit and surround paths. Register extremes and random
// traffic follow, with sender gaps and receiver stalls in several mixes.
// ---------------------------------------------------------------------------
module tb_wall_avoid_motion_fsm;
  import wamf_pkg::*;

  localparam int STALL_LIMIT = 2000;

  localparam logic [2:0] FACE_FRONT = 3'd0;
  localparam logic [2:0] FACE_RIGHT = 3'd1;
  localparam logic [2:0] FACE_BACK  = 3'd2;
  localparam logic [2:0] FACE_LEFT  = 3'd3;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  op = OP_MSG;
  logic [31:0]           time_ms = '0;
  logic [31:0]           payload_head = '0;
  logic [7:0]            payload_len = '0;
  logic [2:0]            face = '0;
  logic                  random_bit = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [NUM_FACES-1:0]  face_leds;
  logic [1:0]            action;
  logic [POWER_W-1:0]    left_power;
  logic                  left_dir;
  logic [POWER_W-1:0]    right_power;
  logic                  right_dir;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  wall_avoid_motion_fsm u_dut (.*);

  always #5 clk = ~clk;

  // controller copy
  logic [TIME_W-1:0] wall_stamp [NUM_FACES];
  move_t             ctl_action;
  logic [TIME_W-1:0] ctl_deadline;
  cfg_t              ctl_cfg;
  result_t           motion_due [$];

  int          send_gap_pct = 0;
  int          stall_pct = 0;
  int          ms_step = 60;
  logic [31:0] ms_now = '0;
  int          items_sent = 0;
  int          ticks_sent = 0;
  int          results_checked = 0;
  int          mismatches = 0;
  int          idle_cycles = 0;
  int          action_seen [4] = '{0, 0, 0, 0};

  function automatic logic wall_active(int f, logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] age;
    age = now - wall_stamp[f];
    return (wall_stamp[f] != '0) && (age <= ctl_cfg.wall_memory_time);
  endfunction

  function automatic void begin_turn(move_t dir, logic [TIME_W-1:0] now);
    ctl_action = dir;
    ctl_deadline = now + ctl_cfg.turn_time;
  endfunction

  function automatic void decide_motion(logic [TIME_W-1:0] now, logic rnd);
    logic              turning, early, fr, rt, bk, lf;
    logic [TIME_W-1:0] lag;
    move_t             chance;
    int                walls;
    turning = (ctl_action == ACT_LEFT) || (ctl_action == ACT_RIGHT);
    lag = now - ctl_deadline;
    early = lag[TIME_W-1];
    chance = rnd ? ACT_LEFT : ACT_RIGHT;
    if (turning && early) return;
    fr = wall_active(0, now);
    rt = wall_active(1, now);
    bk = wall_active(2, now);
    lf = wall_active(3, now);
    walls = $countones({fr, rt, bk, lf});
    if (walls >= 3) begin
      if (ctl_action == ACT_FWD) begin
        begin_turn(chance, now);
        return;
      end
      if (turning) begin
        // boxed in: long commit and forget every wall
        ctl_action = ACT_COMMIT;
        ctl_deadline = now + (ctl_cfg.commit_time << 1);
        foreach (wall_stamp[i]) wall_stamp[i] = '0;
        return;
      end
      if (early) return;
    end
    if (ctl_action == ACT_COMMIT && early) begin
      if (fr) begin_turn(chance, now);
      return;
    end
    if (turning) begin
      ctl_action = ACT_COMMIT;
      ctl_deadline = now + ctl_cfg.commit_time;
      return;
    end
    if (fr) begin
      if (lf && !rt) begin_turn(ACT_RIGHT, now);
      else if (rt && !lf) begin_turn(ACT_LEFT, now);
      else begin_turn(chance, now);
    end else if (lf && !rt) begin
      begin_turn(ACT_RIGHT, now);
    end else if (rt && !lf) begin
      begin_turn(ACT_LEFT, now);
    end else begin
      ctl_action = ACT_FWD;
    end
  endfunction

  function automatic result_t step_controller(item_t it);
    result_t r;
    if (it.op == OP_MSG && it.payload_len >= MIN_WALL_LEN && it.payload_head == WALL_WORD
        && it.face < NUM_FACES)
      wall_stamp[it.face[FACE_IDX_W-1:0]] = it.time_ms;
    r.face_leds = '0;
    for (int f = 0; f < NUM_FACES; f++) r.face_leds[f] = wall_active(f, it.time_ms);
    if (it.op == OP_TICK) decide_motion(it.time_ms, it.random_bit);
    r.action = ctl_action;
    r.left_power = ctl_cfg.left_cal_power;
    r.left_dir = ctl_cfg.left_cal_dir;
    r.right_power = ctl_cfg.right_cal_power;
    r.right_dir = ctl_cfg.right_cal_dir;
    if (ctl_action == ACT_LEFT || ctl_action == ACT_RIGHT) begin
      r.left_power = ctl_cfg.half_power;
      r.right_power = ctl_cfg.half_power;
    end
    if (ctl_action == ACT_LEFT) r.left_dir = ~r.left_dir;
    if (ctl_action == ACT_RIGHT) r.right_dir = ~r.right_dir;
    return r;
  endfunction

  function automatic item_t make_item(logic o, logic [31:0] t, logic [31:0] head,
                                      logic [7:0] len, logic [2:0] f, logic rnd);
    item_t it;
    it = '{o, t, head, len, f, rnd};
    return it;
  endfunction

  function automatic item_t next_traffic_item();
    item_t it;
    int    roll;
    roll = $urandom_range(0, 99);
    // mostly small steps forward; now and then a jump anywhere, to zero or near the wrap
    if (roll < 3) ms_now = $urandom;
    else if (roll < 4) ms_now = '0;
    else if (roll < 6) ms_now = 32'hFFFF_FFFF - $urandom_range(0, 400);
    else ms_now = ms_now + $urandom_range(0, ms_step);
    it.time_ms = ms_now;
    it.payload_head = $urandom;
    it.payload_len = 8'($urandom);
    it.face = 3'($urandom);
    it.random_bit = 1'($urandom);
    roll = $urandom_range(0, 99);
    it.op = (roll < 40) ? OP_TICK : OP_MSG;
    if (roll >= 40 && roll < 80) begin
      it.payload_head = WALL_WORD;
      it.payload_len = 8'($urandom_range(4, 255));
      it.face = 3'($urandom_range(0, 3));
    end else if (roll >= 80 && roll < 88) begin
      // one bit away from the wall word
      it.payload_head = WALL_WORD ^ (32'd1 << $urandom_range(0, 31));
      it.payload_len = 8'($urandom_range(4, 255));
      it.face = 3'($urandom_range(0, 3));
    end else if (roll >= 88 && roll < 93) begin
      it.payload_head = WALL_WORD;
      it.payload_len = 8'($urandom_range(0, 3));
      it.face = 3'($urandom_range(0, 3));
    end else if (roll >= 93 && roll < 97) begin
      it.payload_head = WALL_WORD;
      it.payload_len = 8'($urandom_range(4, 255));
      it.face = 3'($urandom_range(4, 7));
    end
    return it;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at %0t, result %0d: %s got %0h want %0h",
             $time, results_checked, what, got, want);
  endtask

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin : scoreboard
    result_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (motion_due.size() == 0) begin
          report_mismatch("result with nothing pending", 32'(action), '0);
        end else begin
          want = motion_due.pop_front();
          if (face_leds !== want.face_leds)
            report_mismatch("face_leds", 32'(face_leds), 32'(want.face_leds));
          if (action !== want.action)
            report_mismatch("action", 32'(action), 32'(want.action));
          if (left_power !== want.left_power)
            report_mismatch("left_power", 32'(left_power), 32'(want.left_power));
          if (left_dir !== want.left_dir)
            report_mismatch("left_dir", 32'(left_dir), 32'(want.left_dir));
          if (right_power !== want.right_power)
            report_mismatch("right_power", 32'(right_power), 32'(want.right_power));
          if (right_dir !== want.right_dir)
            report_mismatch("right_dir", 32'(right_dir), 32'(want.right_dir));
          action_seen[want.action]++;
          results_checked++;
        end
      end
      if (in_valid && !in_stall)
        motion_due.push_back(step_controller(item_t'{op, time_ms, payload_head, payload_len,
                                                     face, random_bit}));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("no handshake for %0d cycles, %0d results outstanding",
               idle_cycles, motion_due.size());
      $display("wall_avoid_motion_fsm regression: fail");
      $finish;
    end
  end

  task automatic send_item(item_t it);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    op <= it.op;
    time_ms <= it.time_ms;
    payload_head <= it.payload_head;
    payload_len <= it.payload_len;
    face <= it.face;
    random_bit <= it.random_bit;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (it.op == OP_TICK) ticks_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (motion_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_WALL_MEM:    ctl_cfg.wall_memory_time = value;
      REG_TURN:        ctl_cfg.turn_time = value;
      REG_COMMIT:      ctl_cfg.commit_time = value;
      REG_LEFT_POWER:  ctl_cfg.left_cal_power = value[POWER_W-1:0];
      REG_LEFT_DIR:    ctl_cfg.left_cal_dir = value[0];
      REG_RIGHT_POWER: ctl_cfg.right_cal_power = value[POWER_W-1:0];
      REG_RIGHT_DIR:   ctl_cfg.right_cal_dir = value[0];
      REG_HALF_POWER:  ctl_cfg.half_power = value[POWER_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_registers(logic [31:0] mem, turn, commit, lpow, ldir, rpow, rdir,
                                half);
    wait_idle();
    write_reg(REG_WALL_MEM, mem);
    write_reg(REG_TURN, turn);
    write_reg(REG_COMMIT, commit);
    write_reg(REG_LEFT_POWER, lpow);
    write_reg(REG_LEFT_DIR, ldir);
    write_reg(REG_RIGHT_POWER, rpow);
    write_reg(REG_RIGHT_DIR, rdir);
    write_reg(REG_HALF_POWER, half);
    cfg_write <= 1'b0;
  endtask

  task automatic run_traffic(int count, int step);
    int sent, lead, width;
    ms_step = step;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 9) == 0) begin
        // walls closing in on three or four sides at the same moment
        lead = $urandom_range(0, 3);
        width = $urandom_range(3, 4);
        for (int k = 0; k < width; k++)
          send_item(make_item(OP_MSG, ms_now, WALL_WORD, 8'($urandom_range(4, 255)),
                              3'((lead + k) % NUM_FACES), 1'($urandom)));
        sent += width;
      end else begin
        send_item(next_traffic_item());
        sent++;
      end
    end
  endtask

  task automatic test_directed_walls();
    // reset values of the registers first
    send_item(make_item(OP_TICK, 32'd10, '0, 8'd0, FACE_FRONT, 1'b0));
    // a wall stamped at zero reads as never seen
    send_item(make_item(OP_MSG, 32'd0, WALL_WORD, 8'd4, FACE_FRONT, 1'b0));
    send_item(make_item(OP_TICK, 32'd0, '0, 8'd0, FACE_FRONT, 1'b1));
    load_registers(32'd1000, TURN_RESET, COMMIT_RESET, 32'h155, 32'd1, 32'h2AA, 32'd0,
                   32'(HALF_POWER_RESET));
    send_item(make_item(OP_MSG, 32'd20, WALL_WORD, 8'd8, 3'd4, 1'b0));
    send_item(make_item(OP_MSG, 32'd20, WALL_WORD, 8'd8, 3'd7, 1'b1));
    send_item(make_item(OP_MSG, 32'd30, WALL_WORD, 8'd3, FACE_RIGHT, 1'b0));
    send_item(make_item(OP_MSG, 32'd30, 32'h7761_6C6B, 8'd4, FACE_RIGHT, 1'b0));
    send_item(make_item(OP_MSG, 32'd30, 32'hFFFF_FFFF, 8'd255, FACE_BACK, 1'b1));
    send_item(make_item(OP_MSG, 32'd30, '0, 8'd0, FACE_LEFT, 1'b0));
    send_item(make_item(OP_MSG, 32'd50, WALL_WORD, 8'd255, FACE_RIGHT, 1'b0));
    // right wall alone: spin left, hold, then commit
    send_item(make_item(OP_TICK, 32'd60, '0, 8'd0, FACE_FRONT, 1'b0));
    send_item(make_item(OP_TICK, 32'd200, '0, 8'd0, FACE_FRONT, 1'b1));
    send_item(make_item(OP_TICK, 32'd400, '0, 8'd0, FACE_FRONT, 1'b1));
    // front wall during a commit
    send_item(make_item(OP_MSG, 32'd500, WALL_WORD, 8'd4, FACE_FRONT, 1'b0));
    send_item(make_item(OP_TICK, 32'd600, '0, 8'd0, FACE_FRONT, 1'b0));
    send_item(make_item(OP_TICK, 32'd1000, '0, 8'd0, FACE_FRONT, 1'b0));
    // surrounded on three sides
    send_item(make_item(OP_MSG, 32'd2100, WALL_WORD, 8'd4, FACE_RIGHT, 1'b0));
    send_item(make_item(OP_MSG, 32'd2100, WALL_WORD, 8'd4, FACE_BACK, 1'b0));
    send_item(make_item(OP_MSG, 32'd2100, WALL_WORD, 8'd4, FACE_LEFT, 1'b0));
    send_item(make_item(OP_TICK, 32'd2105, '0, 8'd0, FACE_FRONT, 1'b1));
    send_item(make_item(OP_TICK, 32'd2110, '0, 8'd0, FACE_FRONT, 1'b1));
    send_item(make_item(OP_TICK, 32'd2420, '0, 8'd0, FACE_FRONT, 1'b0));
    send_item(make_item(OP_TICK, 32'd2500, '0, 8'd0, FACE_FRONT, 1'b0));
    // stamp just before the time wraps, read just after
    send_item(make_item(OP_MSG, 32'hFFFF_FF00, WALL_WORD, 8'd4, FACE_LEFT, 1'b0));
    send_item(make_item(OP_TICK, 32'h0000_0010, '0, 8'd0, FACE_FRONT, 1'b0));
  endtask

  task automatic test_register_extremes();
    load_registers('0, '0, '0, '0, '0, '0, '0, '0);
    run_traffic(100, 2);
    // longest memory and turn, commit doubling to a wrapped zero, 10-bit fields overfilled
    load_registers(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_traffic(100, 200);
  endtask

  task automatic test_random_traffic(int sender_pct, int receiver_pct, int count);
    send_gap_pct = sender_pct;
    stall_pct = receiver_pct;
    load_registers($urandom_range(50, 700), $urandom_range(10, 500), $urandom_range(10, 900),
                   $urandom, $urandom, $urandom, $urandom, $urandom);
    run_traffic(count, 60);
  endtask

  initial begin
    foreach (wall_stamp[i]) wall_stamp[i] = '0;
    ctl_action = ACT_FWD;
    ctl_deadline = '0;
    ctl_cfg = '{WALL_MEM_RESET, TURN_RESET, COMMIT_RESET, '0, 1'b0, '0, 1'b0,
                HALF_POWER_RESET};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_gap_pct = 26;
    stall_pct = 75;
    test_directed_walls();
    test_register_extremes();
    test_random_traffic(26, 75, 250);
    test_random_traffic(75, 26, 320);
    test_random_traffic(0, 0, 320);
    wait_idle();
    $display("covered %0d items (%0d ticks) over seven register settings and three idling mixes",
             items_sent, ticks_sent);
    $display("%0d results checked: %0d forward, %0d left, %0d right, %0d committed",
             results_checked, action_seen[ACT_FWD], action_seen[ACT_LEFT],
             action_seen[ACT_RIGHT], action_seen[ACT_COMMIT]);
    if (mismatches == 0) begin
      $display("wall_avoid_motion_fsm regression: pass");
    end else begin
      $display("wall_avoid_motion_fsm regression: fail");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/wamf_pkg.sv
sv/wamf_decide.sv
sv/wall_avoid_motion_fsm.sv
sv/wamf_checker.sv
tb/tb_wall_avoid_motion_fsm.sv
